// File: src/lpg_pkg.sv
// shared types and defaults for the line pixel generator
// no dependencies; imported by every other file of the block but lpg_queue
package lpg_pkg;

  // default coordinate and color widths
  localparam int COORD_BITS_DEF = 16;
  localparam int COLOR_BITS_DEF = 8;

  // request type codes
  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_ADVANCE = 1'b1;

  // how a line is walked
  typedef enum logic [1:0] {
    MODE_HORIZ   = 2'd0,
    MODE_VERT    = 2'd1,
    MODE_COL_MAJ = 2'd2,
    MODE_ROW_MAJ = 2'd3
  } line_mode_t;

endpackage

// File: src/lpg_if.sv
// valid/ready channel interfaces for requests and pixels
// depends on lpg_pkg for default widths
interface lpg_req_if
  import lpg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int COLOR_BITS = COLOR_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  req_type;
  logic [COORD_BITS-1:0] start_col;
  logic [COORD_BITS-1:0] start_row;
  logic [COORD_BITS-1:0] end_col;
  logic [COORD_BITS-1:0] end_row;
  logic [COLOR_BITS-1:0] pen_color;

  modport source (
    output valid, req_type, start_col, start_row, end_col, end_row, pen_color,
    input  ready
  );
  modport sink (
    input  valid, req_type, start_col, start_row, end_col, end_row, pen_color,
    output ready
  );
endinterface

interface lpg_pix_if
  import lpg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int COLOR_BITS = COLOR_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_col;
  logic [COORD_BITS-1:0] pixel_row;
  logic [COLOR_BITS-1:0] pixel_color;
  logic                  last_pixel;

  modport source (
    output valid, pixel_col, pixel_row, pixel_color, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, pixel_col, pixel_row, pixel_color, last_pixel,
    output ready
  );
endinterface

// File: src/lpg_front.sv
// front end: classifies requests and works out line setup on load
// depends on lpg_pkg; feeds a packed command word into lpg_queue
module lpg_front
  import lpg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int COLOR_BITS = COLOR_BITS_DEF,
  localparam int CMD_BITS  = 1 + 2 + 1 + 2 * COORD_BITS + (COORD_BITS + 1)
                             + COORD_BITS + COLOR_BITS
) (
  input  logic                  req_type,
  input  logic [COORD_BITS-1:0] start_col,
  input  logic [COORD_BITS-1:0] start_row,
  input  logic [COORD_BITS-1:0] end_col,
  input  logic [COORD_BITS-1:0] end_row,
  input  logic [COLOR_BITS-1:0] pen_color,
  output logic [CMD_BITS-1:0]   cmd
);

  logic                  swap;
  logic [COORD_BITS-1:0] c1, r1, c2, r2;
  logic [COORD_BITS-1:0] drow, dcol;
  logic                  neg;
  line_mode_t            mode;
  logic                  col_neg;
  logic [COORD_BITS-1:0] base_col;
  logic [COORD_BITS:0]   major_len;
  logic [COORD_BITS-1:0] minor_delta;

  // order endpoints so the start row is the smaller
  always_comb begin
    swap = end_row < start_row;
    c1   = swap ? end_col   : start_col;
    r1   = swap ? end_row   : start_row;
    c2   = swap ? start_col : end_col;
    r2   = swap ? start_row : end_row;
    drow = r2 - r1;
    neg  = c2 < c1;
    dcol = neg ? (c1 - c2) : (c2 - c1);
  end

  // pick walk mode and lengths
  always_comb begin
    base_col    = c1;
    col_neg     = neg;
    minor_delta = '0;
    if (drow == '0) begin
      mode      = MODE_HORIZ;
      base_col  = neg ? c2 : c1;
      major_len = {1'b0, dcol} + 1'b1;
      col_neg   = 1'b0;
    end else if (dcol == '0) begin
      mode      = MODE_VERT;
      major_len = {1'b0, drow} + 1'b1;
      col_neg   = 1'b0;
    end else if (dcol > drow) begin
      mode        = MODE_COL_MAJ;
      major_len   = {1'b0, dcol};
      minor_delta = drow;
    end else begin
      mode        = MODE_ROW_MAJ;
      major_len   = {1'b0, drow};
      minor_delta = dcol;
    end
  end

  // command word layout, mirrored in lpg_back
  assign cmd = {req_type, mode, col_neg, base_col, r1, major_len, minor_delta, pen_color};

endmodule

// File: src/lpg_queue.sv
// two-entry queue between front and back, one push and one pop per cycle
// no package dependency
module lpg_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  logic [1:0]       count;
  logic [WIDTH-1:0] head;
  logic [WIDTH-1:0] tail;

  assign full       = count == 2'd2;
  assign head_valid = count != 2'd0;
  assign head_data  = head;

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  // entry shifting
  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (count == 2'd1) begin
        head <= push_data;
      end else begin
        head <= tail;
        tail <= push_data;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        head <= push_data;
      end else begin
        tail <= push_data;
      end
    end else if (pop) begin
      head <= tail;
    end
  end

endmodule

// File: src/lpg_back.sv
// back end: holds the active line and steps it one pixel per advance word
// depends on lpg_pkg; takes command words from lpg_queue
module lpg_back
  import lpg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int COLOR_BITS = COLOR_BITS_DEF,
  localparam int CMD_BITS  = 1 + 2 + 1 + 2 * COORD_BITS + (COORD_BITS + 1)
                             + COORD_BITS + COLOR_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  logic [CMD_BITS-1:0] cmd,
  output logic                cmd_pop,
  lpg_pix_if.source           pix
);

  // unpacked command
  logic                  c_type;
  line_mode_t            c_mode;
  logic                  c_neg;
  logic [COORD_BITS-1:0] c_col, c_row;
  logic [COORD_BITS:0]   c_major;
  logic [COORD_BITS-1:0] c_minor;
  logic [COLOR_BITS-1:0] c_color;

  assign {c_type, c_mode, c_neg, c_col, c_row, c_major, c_minor, c_color} = cmd;

  // line state
  logic                  drawing;
  line_mode_t            line_mode;
  logic                  col_neg;
  logic [COORD_BITS-1:0] base_col, base_row;
  logic [COORD_BITS:0]   major_len;
  logic [COORD_BITS-1:0] minor_delta;
  logic [COORD_BITS:0]   step_index;
  logic [COORD_BITS-1:0] minor_offset;
  logic [COORD_BITS:0]   remainder_acc;
  logic [COLOR_BITS-1:0] line_color;

  logic                  out_valid;
  logic                  emit;
  logic [COORD_BITS-1:0] col, row, step_lo, col_major, col_minor;
  logic                  last;
  logic [COORD_BITS:0]   rem_sum;
  logic [COORD_BITS:0]   step_inc;

  // a load word always pops; an advance waits for room in the output register
  assign cmd_pop = cmd_valid && (c_type == REQ_LOAD || !out_valid || pix.ready);
  assign emit    = cmd_pop && c_type == REQ_ADVANCE && drawing;

  // pixel position for the current step
  always_comb begin
    step_lo   = step_index[COORD_BITS-1:0];
    col_major = col_neg ? base_col - step_lo : base_col + step_lo;
    col_minor = col_neg ? base_col - minor_offset : base_col + minor_offset;
    unique case (line_mode)
      MODE_HORIZ: begin
        col = base_col + step_lo;
        row = base_row;
      end
      MODE_VERT: begin
        col = base_col;
        row = base_row + step_lo;
      end
      MODE_COL_MAJ: begin
        col = col_major;
        row = base_row + minor_offset;
      end
      MODE_ROW_MAJ: begin
        col = col_minor;
        row = base_row + step_lo;
      end
      default: begin
        col = base_col;
        row = base_row;
      end
    endcase
    step_inc = step_index + 1'b1;
    last     = step_inc >= major_len;
    rem_sum  = remainder_acc + {1'b0, minor_delta};
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      drawing   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd_pop && c_type == REQ_LOAD) begin
        drawing <= 1'b1;
      end else if (emit && last) begin
        drawing <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pix.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // line registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_mode     <= MODE_HORIZ;
      col_neg       <= 1'b0;
      base_col      <= '0;
      base_row      <= '0;
      major_len     <= '0;
      minor_delta   <= '0;
      step_index    <= '0;
      minor_offset  <= '0;
      remainder_acc <= '0;
      line_color    <= '0;
    end else if (cmd_pop && c_type == REQ_LOAD) begin
      line_mode     <= c_mode;
      col_neg       <= c_neg;
      base_col      <= c_col;
      base_row      <= c_row;
      major_len     <= c_major;
      minor_delta   <= c_minor;
      step_index    <= '0;
      minor_offset  <= '0;
      remainder_acc <= '0;
      line_color    <= c_color;
    end else if (emit && !last) begin
      step_index <= step_inc;
      if (rem_sum >= major_len) begin
        remainder_acc <= rem_sum - major_len;
        minor_offset  <= minor_offset + 1'b1;
      end else begin
        remainder_acc <= rem_sum;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (emit) begin
      pix.pixel_col   <= col;
      pix.pixel_row   <= row;
      pix.pixel_color <= line_color;
      pix.last_pixel  <= last;
    end
  end

  assign pix.valid = out_valid;

endmodule

// File: src/line_pixel_generator.sv
// top level of the line pixel generator
// depends on lpg_pkg, lpg_if, lpg_front, lpg_queue and lpg_back
//
// Line rasterizer. A load word (req_type 0) gives two endpoints and a color;
// each advance word (req_type 1) then yields one pixel, last_pixel marking the
// final one. Horizontal and vertical lines cover both endpoints; other lines
// step |major delta| pixels along the major axis, far end left out, with an
// exact truncated minor offset kept by a running remainder. An advance with
// no active line yields nothing. The block takes one request word per cycle
// while the queue is not full: the front computes load setup combinationally,
// a two-entry queue decouples it from the back, and the back steps the line
// with one add and compare on the remainder per cycle, so pixels leave at one
// per cycle while the sink keeps ready high. An accepted advance word passes
// through the queue and then the output word register before its pixel shows.
module line_pixel_generator
  import lpg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int COLOR_BITS = COLOR_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  lpg_req_if.sink req,
  lpg_pix_if.source pix
);

  localparam int CMD_BITS = 1 + 2 + 1 + 2 * COORD_BITS + (COORD_BITS + 1)
                            + COORD_BITS + COLOR_BITS;

  logic [CMD_BITS-1:0] front_cmd;
  logic [CMD_BITS-1:0] head_cmd;
  logic                q_full;
  logic                q_valid;
  logic                q_pop;

  // request classification and load setup
  lpg_front #(
    .COORD_BITS (COORD_BITS),
    .COLOR_BITS (COLOR_BITS)
  ) u_front (
    .req_type  (req.req_type),
    .start_col (req.start_col),
    .start_row (req.start_row),
    .end_col   (req.end_col),
    .end_row   (req.end_row),
    .pen_color (req.pen_color),
    .cmd       (front_cmd)
  );

  assign req.ready = !q_full;

  // command queue
  lpg_queue #(
    .WIDTH (CMD_BITS)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (req.valid && !q_full),
    .push_data  (front_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (head_cmd)
  );

  // line stepping and pixel output
  lpg_back #(
    .COORD_BITS (COORD_BITS),
    .COLOR_BITS (COLOR_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd       (head_cmd),
    .cmd_pop   (q_pop),
    .pix       (pix)
  );

endmodule

// File: test/tb_top.sv
// testbench for line_pixel_generator: random and directed lines, checked pixel by pixel
// depends on lpg_pkg and the lpg_req_if / lpg_pix_if interfaces from the block sources
module tb_top
  import lpg_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = COORD_BITS_DEF;
  localparam int KW = COLOR_BITS_DEF;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_ITEMS = 2000;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic          req_type;
    logic [CW-1:0] start_col;
    logic [CW-1:0] start_row;
    logic [CW-1:0] end_col;
    logic [CW-1:0] end_row;
    logic [KW-1:0] pen_color;
  } req_word_t;

  typedef struct packed {
    logic [CW-1:0] col;
    logic [CW-1:0] row;
    logic [KW-1:0] color;
    logic          last;
  } pixel_t;

  // tracks the active line and holds the pixels still owed by the block
  class line_tracker;
    bit            active;
    line_mode_t    mode;
    logic [CW-1:0] org_col;
    logic [CW-1:0] org_row;
    logic [16:0]   span;
    logic [16:0]   minor_span;
    logic [16:0]   step;
    logic [16:0]   offset;
    logic [16:0]   rem;
    logic [KW-1:0] color;
    bit            col_down;
    pixel_t        pending[$];
    int            mismatches;
    int            checked;
    int            lines_done;
    int            idle_advances;
    int            loads;
    int            longest;

    function new();
      active = 0;
      mode = MODE_HORIZ;
      org_col = '0;
      org_row = '0;
      span = '0;
      minor_span = '0;
      step = '0;
      offset = '0;
      rem = '0;
      color = '0;
      col_down = 0;
      mismatches = 0;
      checked = 0;
      lines_done = 0;
      idle_advances = 0;
      loads = 0;
      longest = 0;
    endfunction

    // returns 1 when the word changes the state or owes a pixel
    function bit note_request(req_word_t w);
      logic [CW-1:0] c1, r1, c2, r2, tmp;
      logic [CW:0]   dc, dr;
      logic [17:0]   csum, rsum, acc;
      pixel_t        p;
      if (w.req_type == REQ_LOAD) begin
        c1 = w.start_col;
        r1 = w.start_row;
        c2 = w.end_col;
        r2 = w.end_row;
        // order endpoints so the start row is the smaller
        if (r2 < r1) begin
          tmp = c1; c1 = c2; c2 = tmp;
          tmp = r1; r1 = r2; r2 = tmp;
        end
        dr = r2 - r1;
        col_down = c2 < c1;
        dc = col_down ? c1 - c2 : c2 - c1;
        org_row = r1;
        org_col = c1;
        minor_span = '0;
        if (dr == 0) begin
          mode = MODE_HORIZ;
          org_col = col_down ? c2 : c1;
          span = dc + 17'd1;
          col_down = 0;
        end else if (dc == 0) begin
          mode = MODE_VERT;
          span = dr + 17'd1;
          col_down = 0;
        end else if (dc > dr) begin
          mode = MODE_COL_MAJ;
          span = dc;
          minor_span = dr;
        end else begin
          mode = MODE_ROW_MAJ;
          span = dr;
          minor_span = dc;
        end
        step = '0;
        offset = '0;
        rem = '0;
        color = w.pen_color;
        active = 1;
        loads++;
        if (int'(span) > longest) longest = int'(span);
        return 1;
      end
      if (!active) begin
        idle_advances++;
        return 0;
      end
      // pixel position from the step count and the minor offset
      case (mode)
        MODE_HORIZ: begin
          csum = org_col + step;
          rsum = org_row;
        end
        MODE_VERT: begin
          csum = org_col;
          rsum = org_row + step;
        end
        MODE_COL_MAJ: begin
          csum = col_down ? org_col - step : org_col + step;
          rsum = org_row + offset;
        end
        default: begin
          csum = col_down ? org_col - offset : org_col + offset;
          rsum = org_row + step;
        end
      endcase
      p.col = csum[CW-1:0];
      p.row = rsum[CW-1:0];
      p.color = color;
      p.last = ({1'b0, step} + 18'd1) >= {1'b0, span};
      pending.push_back(p);
      // advance the running remainder
      if (p.last) begin
        active = 0;
      end else begin
        step = step + 17'd1;
        acc = rem + minor_span;
        if (acc >= {1'b0, span}) begin
          acc = acc - span;
          offset = offset + 17'd1;
        end
        rem = acc[16:0];
      end
      return 1;
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected pixel: col %h row %h color %h last %b",
                   got.col, got.row, got.color, got.last);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (want.last) lines_done++;
      if (got.col !== want.col || got.row !== want.row ||
          got.color !== want.color || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("pixel %0d mismatch: expected col %h row %h color %h last %b",
                   checked, want.col, want.row, want.color, want.last);
          $display("  got col %h row %h color %h last %b",
                   got.col, got.row, got.color, got.last);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   idle_on = 1'b1;
  int   cycle_count = 0;
  int   effective_items = 0;
  int   words_sent = 0;
  line_tracker tracker = new();

  lpg_req_if #(.COORD_BITS(CW), .COLOR_BITS(KW)) req_ch ();
  lpg_pix_if #(.COORD_BITS(CW), .COLOR_BITS(KW)) pix_ch ();

  line_pixel_generator #(.COORD_BITS(CW), .COLOR_BITS(KW)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .pix (pix_ch)
  );

  // clock and run limit
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  // known values on all block inputs from time zero
  initial begin
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_LOAD;
    req_ch.start_col = '0;
    req_ch.start_row = '0;
    req_ch.end_col = '0;
    req_ch.end_row = '0;
    req_ch.pen_color = '0;
    pix_ch.ready = 1'b0;
  end

  // pixel sink with random stalls
  initial begin
    int     stall;
    pixel_t got;
    wait (rst == 1'b0);
    forever begin
      stall = idle_on ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        pix_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pix_ch.ready <= 1'b1;
      @(posedge clk);
      while (pix_ch.valid !== 1'b1) @(posedge clk);
      got.col = pix_ch.pixel_col;
      got.row = pix_ch.pixel_row;
      got.color = pix_ch.pixel_color;
      got.last = pix_ch.last_pixel;
      tracker.check_pixel(got);
    end
  end

  // one request word, with a random gap before it
  task automatic send_word(input req_word_t w);
    int gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= w.req_type;
    req_ch.start_col <= w.start_col;
    req_ch.start_row <= w.start_row;
    req_ch.end_col <= w.end_col;
    req_ch.end_row <= w.end_row;
    req_ch.pen_color <= w.pen_color;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    words_sent++;
    if (tracker.note_request(w)) effective_items++;
  endtask

  task automatic send_load(input int sc, input int sr, input int ec, input int er,
                           input int color);
    req_word_t w;
    w.req_type = REQ_LOAD;
    w.start_col = sc[CW-1:0];
    w.start_row = sr[CW-1:0];
    w.end_col = ec[CW-1:0];
    w.end_row = er[CW-1:0];
    w.pen_color = color[KW-1:0];
    send_word(w);
  endtask

  // advance word; the unused coordinate fields carry noise
  task automatic send_advance();
    req_word_t w;
    w.req_type = REQ_ADVANCE;
    w.start_col = CW'($urandom());
    w.start_row = CW'($urandom());
    w.end_col = CW'($urandom());
    w.end_row = CW'($urandom());
    w.pen_color = KW'($urandom());
    send_word(w);
  endtask

  task automatic draw_line(input int sc, input int sr, input int ec, input int er,
                           input int color, input int n_adv);
    send_load(sc, sr, ec, er, color);
    repeat (n_adv) send_advance();
  endtask

  // hold requests until every owed pixel has come out
  task automatic wait_drained();
    if (tracker.pending.size() != 0) begin
      req_ch.valid <= 1'b0;
      while (tracker.pending.size() != 0) @(posedge clk);
    end
  endtask

  function automatic int near_coord(input int base, input int d);
    int e;
    e = base + d;
    if (e < 0 || e > 65535) e = base - d;
    return e;
  endfunction

  // main sequence
  initial begin
    int kind, shape, n, base_c, base_r, end_c, end_r, dc, dr, start_items;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: idle advance, single point, reversed horizontal and vertical,
    // both diagonal walks, a replaced line and advances past the end
    send_advance();
    draw_line(65535, 0, 65535, 0, 255, 1);
    draw_line(2, 7, 0, 7, 0, 3);
    draw_line(0, 65535, 0, 65534, 170, 2);
    draw_line(65535, 0, 65532, 2, 85, 3);
    draw_line(5, 0, 7, 3, 1, 3);
    draw_line(0, 0, 65535, 65535, 128, 2);
    draw_line(0, 0, 1, 0, 90, 3);
    wait_drained();

    // opening stretch of a full-height line with no idling
    idle_on = 1'b0;
    send_load(65535, 0, $urandom_range(1, 65534), 65535, $urandom());
    repeat (64) send_advance();
    wait_drained();
    idle_on = 1'b1;

    // random lines, mostly drawn to the end
    start_items = effective_items;
    while (effective_items - start_items < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        send_advance();
      end else begin
        shape = $urandom_range(0, 19);
        base_c = $urandom_range(0, 65535);
        base_r = $urandom_range(0, 65535);
        dc = $urandom_range(0, 24) - 12;
        dr = $urandom_range(0, 24) - 12;
        if (shape == 1) begin
          dc = 0;
          dr = 0;
        end else if (shape < 4) begin
          dr = 0;
        end else if (shape < 6) begin
          dc = 0;
        end
        end_c = near_coord(base_c, dc);
        end_r = near_coord(base_r, dr);
        if (shape == 0) begin
          end_c = $urandom_range(0, 65535);
          end_r = $urandom_range(0, 65535);
        end
        send_load(base_c, base_r, end_c, end_r, $urandom());
        if (shape == 0 || kind < 20) begin
          n = $urandom_range(0, 15);
          repeat (n) send_advance();
        end else begin
          while (tracker.active) send_advance();
        end
        if ($urandom_range(0, 7) == 0) send_advance();
      end
      if ($urandom_range(0, 15) == 0) wait_drained();
      if ($urandom_range(0, 31) == 0) idle_on = !idle_on;
    end

    // let the last pixels out, then watch for strays
    idle_on = 1'b1;
    req_ch.valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d request words: %0d loads, %0d advances with no line active",
             words_sent, tracker.loads, tracker.idle_advances);
    $display("%0d pixels compared, %0d lines drawn to the end,",
             tracker.checked, tracker.lines_done);
    $display("longest line %0d pixels, %0d mismatches",
             tracker.longest, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
src/lpg_pkg.sv
src/lpg_if.sv
src/lpg_front.sv
src/lpg_queue.sv
src/lpg_back.sv
src/line_pixel_generator.sv
test/tb_top.sv
